/* src/edd_pkg.sv */
`timescale 1ns / 1ps
package edd_pkg;

  // Sizing of the dispatcher
  localparam int FLOORS     = 6;
  localparam int WAIT_DEPTH = 16;
  localparam int CAR_DEPTH  = 8;

  // Derived widths
  localparam int FL_W   = $clog2(FLOORS);
  localparam int WI_W   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WC_W   = $clog2(WAIT_DEPTH + 1);
  localparam int CI_W   = (CAR_DEPTH > 1) ? $clog2(CAR_DEPTH) : 1;
  localparam int CC_W   = $clog2(CAR_DEPTH + 1);
  localparam int SCAN_W = (WC_W > CC_W) ? WC_W : CC_W;

  // Item field widths
  localparam int IN_FLOOR_W  = 3;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_FLOOR_W = 3;
  localparam int OUT_RIDER_W = 4;
  localparam int OUT_WAIT_W  = 5;
  localparam int OUT_CNT_W   = 4;
  localparam int OUT_DATA_W  = 24;

  // Input kinds carried on tuser
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // Request to the shared scan compare unit
  typedef struct packed {
    logic            board;       // 1 = boarding pass, 0 = drop-off pass
    logic            force_take;  // oldest call boards unconditionally
    logic [FL_W-1:0] ent_src;
    logic [FL_W-1:0] ent_dst;
    logic [FL_W-1:0] floor;
    logic            heading_up;
    logic            car_full;
  } edd_scan_req_t;

  // Saturate a requested floor to the top of the shaft
  function automatic logic [FL_W-1:0] clamp_floor(input logic [IN_FLOOR_W-1:0] f);
    logic [FL_W-1:0] res;
    res = (int'(f) > FLOORS - 1) ? FL_W'(FLOORS - 1) : FL_W'(f);
    return res;
  endfunction

endpackage

/* src/edd_scan_unit.sv */
`timescale 1ns / 1ps
module edd_scan_unit (
  input  edd_pkg::edd_scan_req_t req,
  output logic                   take
);

  logic call_up;
  logic board_hit;
  logic drop_hit;

  // Caller goes up only for a strictly higher destination
  assign call_up = (req.ent_src < req.ent_dst);

  // Boarding: at this floor, same direction, room in the car
  assign board_hit = req.force_take
                   | ((req.ent_src == req.floor) & (call_up == req.heading_up) & ~req.car_full);

  // Drop-off: rider destination is this floor
  assign drop_hit = (req.ent_dst == req.floor);

  assign take = req.board ? board_hit : drop_hit;

endmodule

/* src/elevator_directional_dispatch.sv */
`timescale 1ns / 1ps
// Directional collective elevator dispatcher. Each input item is either a hall
// call request (in_tuser = 1) that is appended to a 16-entry ordered waiting
// list, or a tick (in_tuser = 0) that runs one step of the car: riders for this
// floor alight, callers at this floor heading the car's way board oldest first,
// and the car moves one floor. An empty car heads toward the oldest caller; with
// no riders and no calls it returns to floor 0. Every item gives exactly one
// result item. The block takes one item at a time: a request or an idle return
// needs no scan, a tick with riders scans the riders and then the waiting calls,
// and a tick of an empty car with calls waiting scans only the calls. A single
// compare unit visits one rider or one waiting call per cycle, and each pass
// ends in a closing step. A finished result waits in the output register while
// the next item is taken; the last step of that next item holds until the
// output register is free.
module elevator_directional_dispatch (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [edd_pkg::IN_DATA_W-1:0]   in_tdata,   // src_floor[2:0], dst_floor[5:3]
  input  logic                            in_tuser,   // mode[0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [edd_pkg::OUT_DATA_W-1:0]  out_tdata   // current_floor[2:0], direction_up[3],
                                                      // riders[7:4], waiting[12:8],
                                                      // boarded[16:13], alighted[20:17],
                                                      // rejected[21]
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DROP,
    ST_BOARD,
    ST_DONE
  } state_t;

  state_t                       state_r;
  logic [edd_pkg::FL_W-1:0]     wait_src_r [edd_pkg::WAIT_DEPTH];
  logic [edd_pkg::FL_W-1:0]     wait_dst_r [edd_pkg::WAIT_DEPTH];
  logic [edd_pkg::FL_W-1:0]     car_dst_r  [edd_pkg::CAR_DEPTH];
  logic [edd_pkg::WC_W-1:0]     wait_count_r;
  logic [edd_pkg::CC_W-1:0]     car_count_r;
  logic [edd_pkg::FL_W-1:0]     car_floor_r;
  logic                         heading_r;
  logic [edd_pkg::SCAN_W-1:0]   scan_r;
  logic [edd_pkg::SCAN_W-1:0]   keep_r;
  logic                         force_r;
  logic                         move_always_r;
  logic [edd_pkg::CC_W-1:0]     boarded_r;
  logic [edd_pkg::CC_W-1:0]     alighted_r;
  logic                         rejected_r;
  logic                         out_tvalid_r;
  logic [edd_pkg::OUT_DATA_W-1:0] out_tdata_r;

  logic [edd_pkg::FL_W-1:0]     rd_src;
  logic [edd_pkg::FL_W-1:0]     rd_dst;
  logic [edd_pkg::FL_W-1:0]     rd_car;
  logic [edd_pkg::FL_W-1:0]     moved_floor;
  edd_pkg::edd_scan_req_t       scan_req;
  logic                         take;

  // Read the entry under the scan pointer
  assign rd_src = wait_src_r[scan_r[edd_pkg::WI_W-1:0]];
  assign rd_dst = wait_dst_r[scan_r[edd_pkg::WI_W-1:0]];
  assign rd_car = car_dst_r[scan_r[edd_pkg::CI_W-1:0]];

  // One floor step, saturating at the shaft ends
  always_comb begin
    moved_floor = car_floor_r;
    if (heading_r) begin
      if (car_floor_r < edd_pkg::FL_W'(edd_pkg::FLOORS - 1)) begin
        moved_floor = car_floor_r + edd_pkg::FL_W'(1);
      end
    end else if (car_floor_r != '0) begin
      moved_floor = car_floor_r - edd_pkg::FL_W'(1);
    end
  end

  // Feed the shared compare unit
  always_comb begin
    scan_req.board      = (state_r == ST_BOARD);
    scan_req.force_take = force_r && (scan_r == '0);
    scan_req.ent_src    = rd_src;
    scan_req.ent_dst    = (state_r == ST_BOARD) ? rd_dst : rd_car;
    scan_req.floor      = car_floor_r;
    scan_req.heading_up = heading_r;
    scan_req.car_full   = (car_count_r == edd_pkg::CC_W'(edd_pkg::CAR_DEPTH));
  end

  edd_scan_unit u_scan (
    .req  (scan_req),
    .take (take)
  );

  // Sequencer, lists and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      wait_count_r  <= '0;
      car_count_r   <= '0;
      car_floor_r   <= '0;
      heading_r     <= 1'b1;
      scan_r        <= '0;
      keep_r        <= '0;
      force_r       <= 1'b0;
      move_always_r <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      // Drop a taken result unless a new one replaces it this cycle
      if (out_tvalid_r && out_tready && state_r != ST_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            boarded_r     <= '0;
            alighted_r    <= '0;
            rejected_r    <= 1'b0;
            scan_r        <= '0;
            keep_r        <= '0;
            force_r       <= 1'b0;
            move_always_r <= 1'b0;
            if (in_tuser == edd_pkg::MODE_REQUEST) begin
              // Append the call, or drop it when the list is full
              if (wait_count_r == edd_pkg::WC_W'(edd_pkg::WAIT_DEPTH)) begin
                rejected_r <= 1'b1;
              end else begin
                wait_src_r[wait_count_r[edd_pkg::WI_W-1:0]] <=
                  edd_pkg::clamp_floor(in_tdata[2:0]);
                wait_dst_r[wait_count_r[edd_pkg::WI_W-1:0]] <=
                  edd_pkg::clamp_floor(in_tdata[5:3]);
                wait_count_r <= wait_count_r + edd_pkg::WC_W'(1);
              end
              state_r <= ST_DONE;
            end else if (car_count_r == '0 && wait_count_r == '0) begin
              // Idle return to the ground floor
              car_floor_r <= '0;
              state_r     <= ST_DONE;
            end else if (car_count_r == '0) begin
              // Empty car: serve or head toward the oldest call
              move_always_r <= 1'b1;
              if (car_floor_r == rd_src) begin
                force_r   <= 1'b1;
                heading_r <= (rd_src < rd_dst);
              end else begin
                heading_r <= (rd_src > car_floor_r);
              end
              state_r <= ST_BOARD;
            end else begin
              state_r <= ST_DROP;
            end
          end
        end
        ST_DROP: begin
          // Let off riders for this floor, compact the rest
          if (scan_r < edd_pkg::SCAN_W'(car_count_r)) begin
            if (take) begin
              alighted_r <= alighted_r + edd_pkg::CC_W'(1);
            end else begin
              car_dst_r[keep_r[edd_pkg::CI_W-1:0]] <= rd_car;
              keep_r <= keep_r + edd_pkg::SCAN_W'(1);
            end
            scan_r <= scan_r + edd_pkg::SCAN_W'(1);
          end else begin
            car_count_r <= edd_pkg::CC_W'(keep_r);
            scan_r      <= '0;
            keep_r      <= '0;
            state_r     <= ST_BOARD;
          end
        end
        ST_BOARD: begin
          // Board matching callers oldest first, compact the list
          if (scan_r < edd_pkg::SCAN_W'(wait_count_r)) begin
            if (take) begin
              car_dst_r[car_count_r[edd_pkg::CI_W-1:0]] <= rd_dst;
              car_count_r <= car_count_r + edd_pkg::CC_W'(1);
              boarded_r   <= boarded_r + edd_pkg::CC_W'(1);
            end else begin
              wait_src_r[keep_r[edd_pkg::WI_W-1:0]] <= rd_src;
              wait_dst_r[keep_r[edd_pkg::WI_W-1:0]] <= rd_dst;
              keep_r <= keep_r + edd_pkg::SCAN_W'(1);
            end
            scan_r <= scan_r + edd_pkg::SCAN_W'(1);
          end else begin
            wait_count_r <= edd_pkg::WC_W'(keep_r);
            if (move_always_r || car_count_r != '0) begin
              car_floor_r <= moved_floor;
            end
            scan_r  <= '0;
            keep_r  <= '0;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hand the result to the output register once it is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {2'b00,
                             rejected_r,
                             edd_pkg::OUT_CNT_W'(alighted_r),
                             edd_pkg::OUT_CNT_W'(boarded_r),
                             edd_pkg::OUT_WAIT_W'(wait_count_r),
                             edd_pkg::OUT_RIDER_W'(car_count_r),
                             heading_r,
                             edd_pkg::OUT_FLOOR_W'(car_floor_r)};
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

/* src/edd_checker.sv */
`timescale 1ns / 1ps
module edd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [edd_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [edd_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // Hold an offered item until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input item changed while waiting");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A rejected request only happens with a full list
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |->
      out_tdata[12:8] == edd_pkg::OUT_WAIT_W'(edd_pkg::WAIT_DEPTH))
    else $error("rejected request with room in the list");

  // A rejected request moves nobody
  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |-> out_tdata[20:13] == '0)
    else $error("rejected request boarded or dropped riders");

  // Counts stay within the list and car sizes, the floor within the shaft
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(out_tdata[7:4]) <= edd_pkg::CAR_DEPTH) &&
                   (int'(out_tdata[12:8]) <= edd_pkg::WAIT_DEPTH) &&
                   (int'(out_tdata[2:0]) <= edd_pkg::FLOORS - 1))
    else $error("count or floor out of range");

endmodule

bind elevator_directional_dispatch edd_checker u_edd_checker (.*);

/* tb/dispatch_checker.sv */
`timescale 1ns / 1ps
// Watches both channels of the dispatcher, keeps its own model of the car
// and the call list, and checks every result item against the oldest
// outstanding prediction.
module dispatch_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [edd_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [edd_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             fails,
  output int                             pending
);

  typedef struct packed {
    logic [edd_pkg::OUT_FLOOR_W-1:0] floor_no;
    logic                            up;
    logic [edd_pkg::OUT_RIDER_W-1:0] riders;
    logic [edd_pkg::OUT_WAIT_W-1:0]  waiting;
    logic [edd_pkg::OUT_CNT_W-1:0]   boarded;
    logic [edd_pkg::OUT_CNT_W-1:0]   alighted;
    logic                            rejected;
  } car_report_t;

  // Model state: call list, car load, position, heading
  logic [edd_pkg::IN_FLOOR_W-1:0]  call_src [edd_pkg::WAIT_DEPTH];
  logic [edd_pkg::IN_FLOOR_W-1:0]  call_dst [edd_pkg::WAIT_DEPTH];
  logic [edd_pkg::OUT_WAIT_W-1:0]  call_cnt;
  logic [edd_pkg::IN_FLOOR_W-1:0]  rider_dst [edd_pkg::CAR_DEPTH];
  logic [edd_pkg::OUT_RIDER_W-1:0] rider_cnt;
  logic [edd_pkg::IN_FLOOR_W-1:0]  car_at;
  logic                            going_up;

  car_report_t expected_reports[$];
  int          err_cnt = 0;

  assign fails = err_cnt;

  task automatic note(input string msg);
    if (err_cnt < 100) $display("[%0t] %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic logic [edd_pkg::IN_FLOOR_W-1:0] top_clip(
    input logic [edd_pkg::IN_FLOOR_W-1:0] f);
    return (f > edd_pkg::FLOORS - 1) ? edd_pkg::IN_FLOOR_W'(edd_pkg::FLOORS - 1) : f;
  endfunction

  // Board callers at the car's floor going its way, oldest first; close gaps
  task automatic board_along(output int got);
    int keep;
    int i;
    keep = 0;
    got  = 0;
    for (i = 0; i < call_cnt; i++) begin
      if (call_src[i] == car_at && ((call_src[i] < call_dst[i]) == going_up) &&
          rider_cnt < edd_pkg::CAR_DEPTH) begin
        rider_dst[rider_cnt] = call_dst[i];
        rider_cnt++;
        got++;
      end else begin
        call_src[keep] = call_src[i];
        call_dst[keep] = call_dst[i];
        keep++;
      end
    end
    call_cnt = edd_pkg::OUT_WAIT_W'(keep);
  endtask

  // Let off riders bound for this floor
  task automatic let_off(output int left);
    int keep;
    int i;
    keep = 0;
    left = 0;
    for (i = 0; i < rider_cnt; i++) begin
      if (rider_dst[i] == car_at) left++;
      else begin
        rider_dst[keep] = rider_dst[i];
        keep++;
      end
    end
    rider_cnt = edd_pkg::OUT_RIDER_W'(keep);
  endtask

  // One floor step, held at the shaft ends
  task automatic step_floor();
    if (going_up) begin
      if (car_at < edd_pkg::FLOORS - 1) car_at++;
    end else begin
      if (car_at > 0) car_at--;
    end
  endtask

  task automatic advance_car(input logic mode, input logic [edd_pkg::IN_FLOOR_W-1:0] src,
                             input logic [edd_pkg::IN_FLOOR_W-1:0] dst,
                             output car_report_t rep);
    int brd;
    int alt;
    int got;
    int i;
    logic [edd_pkg::IN_FLOOR_W-1:0] s;
    logic [edd_pkg::IN_FLOOR_W-1:0] d;
    brd = 0;
    alt = 0;
    rep = '0;
    if (mode == edd_pkg::MODE_REQUEST) begin
      if (call_cnt >= edd_pkg::WAIT_DEPTH) rep.rejected = 1'b1;
      else begin
        call_src[call_cnt] = top_clip(src);
        call_dst[call_cnt] = top_clip(dst);
        call_cnt++;
      end
    end else if (rider_cnt == 0) begin
      if (call_cnt == 0) car_at = '0;
      else begin
        s = call_src[0];
        d = call_dst[0];
        if (car_at == s) begin
          // Oldest caller boards whatever its direction
          rider_dst[0] = d;
          rider_cnt = 1;
          brd = 1;
          for (i = 1; i < call_cnt; i++) begin
            call_src[i-1] = call_src[i];
            call_dst[i-1] = call_dst[i];
          end
          call_cnt--;
          going_up = (s < d);
        end else begin
          going_up = (s > car_at);
        end
        board_along(got);
        brd += got;
        step_floor();
      end
    end else begin
      let_off(alt);
      board_along(brd);
      if (rider_cnt != 0) step_floor();
    end
    rep.floor_no = car_at;
    rep.up       = going_up;
    rep.riders   = rider_cnt;
    rep.waiting  = call_cnt;
    rep.boarded  = edd_pkg::OUT_CNT_W'(brd);
    rep.alighted = edd_pkg::OUT_CNT_W'(alt);
  endtask

  // Predict on each accepted input item, compare each accepted result item
  always @(posedge clk) begin
    car_report_t want;
    car_report_t seen;
    if (!rst_n) begin
      call_cnt  = '0;
      rider_cnt = '0;
      car_at    = '0;
      going_up  = 1'b1;
      expected_reports.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        advance_car(in_tuser, in_tdata[2:0], in_tdata[5:3], want);
        expected_reports = {expected_reports, want};
      end
      if (out_tvalid && out_tready) begin
        seen.floor_no = out_tdata[2:0];
        seen.up       = out_tdata[3];
        seen.riders   = out_tdata[7:4];
        seen.waiting  = out_tdata[12:8];
        seen.boarded  = out_tdata[16:13];
        seen.alighted = out_tdata[20:17];
        seen.rejected = out_tdata[21];
        if (expected_reports.size() == 0) begin
          note($sformatf("result with nothing outstanding: %h", out_tdata));
        end else begin
          want = expected_reports.pop_front();
          if (seen.floor_no != want.floor_no)
            note($sformatf("current_floor %0d, want %0d", seen.floor_no, want.floor_no));
          if (seen.up != want.up)
            note($sformatf("direction_up %0d, want %0d", seen.up, want.up));
          if (seen.riders != want.riders)
            note($sformatf("riders %0d, want %0d", seen.riders, want.riders));
          if (seen.waiting != want.waiting)
            note($sformatf("waiting %0d, want %0d", seen.waiting, want.waiting));
          if (seen.boarded != want.boarded)
            note($sformatf("boarded %0d, want %0d", seen.boarded, want.boarded));
          if (seen.alighted != want.alighted)
            note($sformatf("alighted %0d, want %0d", seen.alighted, want.alighted));
          if (seen.rejected != want.rejected)
            note($sformatf("rejected %0d, want %0d", seen.rejected, want.rejected));
        end
      end
    end
    pending <= expected_reports.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [edd_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           in_tuser   = edd_pkg::MODE_TICK;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [edd_pkg::OUT_DATA_W-1:0] out_tdata;
  int                             fails;
  int                             pending;

  int calls_sent = 0;
  bit calm       = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  elevator_directional_dispatch dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  dispatch_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fails     (fails),
    .pending   (pending)
  );

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // Mostly real floors, now and then one or two past the top of the shaft
  function automatic logic [edd_pkg::IN_FLOOR_W-1:0] any_floor();
    return ($urandom_range(0, 9) < 9) ?
             edd_pkg::IN_FLOOR_W'($urandom_range(0, edd_pkg::FLOORS - 1)) :
             edd_pkg::IN_FLOOR_W'($urandom_range(edd_pkg::FLOORS, 7));
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic mode, input logic [edd_pkg::IN_FLOOR_W-1:0] src,
                           input logic [edd_pkg::IN_FLOOR_W-1:0] dst);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, dst, src};
    do @(posedge clk); while (!in_tready);
    calls_sent++;
  endtask

  task automatic send_tick();
    send_item(edd_pkg::MODE_TICK, edd_pkg::IN_FLOOR_W'($urandom_range(0, 7)),
              edd_pkg::IN_FLOOR_W'($urandom_range(0, 7)));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off to back up the input
  initial begin
    int stall;
    int taken;
    taken = 0;
    forever begin
      stall = (taken == 300) ? 400 : draw_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin
    #5ms;
    $display("elevator_directional_dispatch: mismatch");
    $finish;
  end

  initial begin
    int f;
    int pct;
    bit go_up;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle return, floor extremes, clipping, equal floors, serve and drop
    send_tick();
    send_item(edd_pkg::MODE_REQUEST, 3'd0, 3'd5);
    send_item(edd_pkg::MODE_REQUEST, 3'd7, 3'd6);
    send_item(edd_pkg::MODE_REQUEST, 3'd5, 3'd0);
    send_item(edd_pkg::MODE_REQUEST, 3'd3, 3'd3);
    send_item(edd_pkg::MODE_REQUEST, 3'd6, 3'd1);
    send_item(edd_pkg::MODE_REQUEST, 3'd2, 3'd7);
    repeat (18) send_tick();
    drain();

    // Random episodes: mixed traffic at several loads, and crowds at one floor
    while (calls_sent < 1320) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat (40) send_tick();
        f     = $urandom_range(0, edd_pkg::FLOORS - 1);
        go_up = (f == 0) ? 1'b1 : (f == edd_pkg::FLOORS - 1) ? 1'b0 :
                1'($urandom_range(0, 1));
        repeat (11) begin
          if (go_up)
            send_item(edd_pkg::MODE_REQUEST, 3'(f),
                      3'($urandom_range(f + 1, edd_pkg::FLOORS - 1)));
          else
            send_item(edd_pkg::MODE_REQUEST, 3'(f), 3'($urandom_range(0, f)));
        end
        repeat (30) send_tick();
      end else begin
        case ($urandom_range(0, 2))
          0:       pct = 25;
          1:       pct = 50;
          default: pct = 85;
        endcase
        repeat (40) begin
          if ($urandom_range(0, 99) < pct)
            send_item(edd_pkg::MODE_REQUEST, any_floor(), any_floor());
          else
            send_tick();
        end
      end
      if (calls_sent >= 700 && calls_sent < 781) drain();
    end

    drain();
    repeat (40) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("elevator_directional_dispatch: match");
    end else begin
      $display("elevator_directional_dispatch: mismatch");
    end
    $finish;
  end

endmodule
